// File: rtl/lse_pkg.sv
`default_nettype none

package lse_pkg;

    // Fixed stream layout
    localparam int LSE_HEADER_BYTES    = 54;
    localparam int LSE_MAGIC_MAX_BYTES = 8;
    localparam int LSE_WORD_BITS       = 32;
    localparam int LSE_BYTE_BITS       = 8;

    // Register file
    localparam int LSE_ADDR_W = 5;
    localparam int LSE_DATA_W = 64;

    localparam logic [1:0] LSE_REG_MAGIC_WORD   = 2'd0;
    localparam logic [1:0] LSE_REG_MAGIC_LENGTH = 2'd1;
    localparam logic [1:0] LSE_REG_EXT_LIMIT    = 2'd2;

    localparam logic [63:0] LSE_MAGIC_WORD_RST   = 64'd10787;
    localparam logic [3:0]  LSE_MAGIC_LENGTH_RST = 4'd2;
    localparam logic [7:0]  LSE_EXT_LIMIT_RST    = 8'd8;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_MAGIC_OK    = 3'd0,
        KIND_EXT_LENGTH  = 3'd1,
        KIND_EXT_CHAR    = 3'd2,
        KIND_PAYLOAD_SIZE = 3'd3,
        KIND_PAYLOAD_BYTE = 3'd4,
        KIND_MAGIC_BAD   = 3'd5,
        KIND_EXT_TOO_LONG = 3'd6
    } lse_kind_t;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_EXTCHR = 3'd3,
        PH_SIZE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_IDLE   = 3'd6
    } lse_phase_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       first_byte;
    } lse_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] size_value;
        logic        last;
    } lse_out_t;

    typedef struct packed {
        logic        valid;
        lse_out_t    data;
    } lse_res_t;

    typedef struct packed {
        logic [63:0] magic_word;
        logic [3:0]  magic_length;
        logic [7:0]  ext_limit;
    } lse_cfg_t;

endpackage

`default_nettype wire

// File: rtl/lse_cfg_regs.sv
`default_nettype none

module lse_cfg_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lse_pkg::LSE_ADDR_W-1:0]  paddr,
    input  wire logic [lse_pkg::LSE_DATA_W-1:0]  pwdata,
    output logic      [lse_pkg::LSE_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output lse_pkg::lse_cfg_t                    cfg
);

    logic [63:0] magic_word_reg;
    logic [3:0]  magic_length_reg;
    logic [7:0]  ext_limit_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign wr_en     = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg   <= lse_pkg::LSE_MAGIC_WORD_RST;
            magic_length_reg <= lse_pkg::LSE_MAGIC_LENGTH_RST;
            ext_limit_reg    <= lse_pkg::LSE_EXT_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                lse_pkg::LSE_REG_MAGIC_WORD:   magic_word_reg   <= pwdata;
                lse_pkg::LSE_REG_MAGIC_LENGTH: magic_length_reg <= pwdata[3:0];
                lse_pkg::LSE_REG_EXT_LIMIT:    ext_limit_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_index)
            lse_pkg::LSE_REG_MAGIC_WORD:   prdata = magic_word_reg;
            lse_pkg::LSE_REG_MAGIC_LENGTH: prdata = {60'd0, magic_length_reg};
            lse_pkg::LSE_REG_EXT_LIMIT:    prdata = {56'd0, ext_limit_reg};
            default:                       prdata = '0;
        endcase
    end

    assign cfg.magic_word   = magic_word_reg;
    assign cfg.magic_length = magic_length_reg;
    assign cfg.ext_limit    = ext_limit_reg;

endmodule

`default_nettype wire

// File: rtl/lse_decoder.sv
`default_nettype none

module lse_decoder
#(
    parameter int MAGIC_MAX_BYTES = lse_pkg::LSE_MAGIC_MAX_BYTES
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               proc,
    input  wire lse_pkg::lse_in_t   item,
    input  wire lse_pkg::lse_cfg_t  cfg,
    output lse_pkg::lse_res_t       res
);

    lse_pkg::lse_phase_t phase_reg, phase_next;
    logic [5:0]  header_count_reg, header_count_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] shift_bits_reg, shift_bits_next;
    logic [7:0]  field_count_reg, field_count_next;
    logic [7:0]  field_target_reg, field_target_next;
    logic        magic_equal_reg, magic_equal_next;
    logic [30:0] payload_left_reg, payload_left_next;

    // State after an optional restart, plus gathered bit
    lse_pkg::lse_phase_t ph;
    logic [5:0]  hc, hc_inc;
    logic [4:0]  bc;
    logic [5:0]  bc_inc;
    logic [31:0] sh, sh_g;
    logic [7:0]  fc, fc_inc, ft, ft_magic;
    logic        meq, meq_g;
    logic [30:0] pl, pl_dec;
    logic        byte_done, word_done, fields_done;
    logic [7:0]  want, b;
    logic [31:0] w;

    always_comb
    begin
        if (item.first_byte)
        begin
            ph = lse_pkg::PH_HEADER;
            hc = '0;
            bc = '0;
            sh = '0;
            fc = '0;
            ft = '0;
            meq = 1'b1;
            pl = '0;
        end
        else
        begin
            ph = phase_reg;
            hc = header_count_reg;
            bc = bit_count_reg;
            sh = shift_bits_reg;
            fc = field_count_reg;
            ft = field_target_reg;
            meq = magic_equal_reg;
            pl = payload_left_reg;
        end

        hc_inc = hc + 6'd1;
        bc_inc = {1'b0, bc} + 6'd1;
        sh_g = sh;
        sh_g[bc] = item.pixel_byte[0];
        byte_done = (bc_inc >= 6'(lse_pkg::LSE_BYTE_BITS));
        word_done = (bc_inc >= 6'(lse_pkg::LSE_WORD_BITS));
        b = sh_g[7:0];
        w = sh_g;
        fc_inc = fc + 8'd1;
        fields_done = (fc_inc >= ft);
        want = cfg.magic_word[{fc[2:0], 3'b000} +: 8];
        meq_g = meq && (b == want);
        pl_dec = pl - 31'd1;

        // Magic length clamped to 1..max
        if (cfg.magic_length == 4'd0)
            ft_magic = 8'd1;
        else if (cfg.magic_length > 4'(MAGIC_MAX_BYTES))
            ft_magic = 8'(MAGIC_MAX_BYTES);
        else
            ft_magic = {4'd0, cfg.magic_length};
    end

    // Next state
    always_comb
    begin
        phase_next        = ph;
        header_count_next = hc;
        bit_count_next    = bc;
        shift_bits_next   = sh;
        field_count_next  = fc;
        field_target_next = ft;
        magic_equal_next  = meq;
        payload_left_next = pl;

        case (ph)
            lse_pkg::PH_HEADER:
            begin
                header_count_next = hc_inc;
                if (hc_inc >= 6'(lse_pkg::LSE_HEADER_BYTES))
                begin
                    phase_next        = lse_pkg::PH_MAGIC;
                    bit_count_next    = '0;
                    shift_bits_next   = '0;
                    field_count_next  = '0;
                    magic_equal_next  = 1'b1;
                    field_target_next = ft_magic;
                end
            end
            lse_pkg::PH_MAGIC, lse_pkg::PH_EXTCHR, lse_pkg::PH_DATA:
            begin
                bit_count_next  = bc_inc[4:0];
                shift_bits_next = sh_g;
                if (byte_done)
                begin
                    bit_count_next  = '0;
                    shift_bits_next = '0;
                    if (ph == lse_pkg::PH_MAGIC)
                    begin
                        magic_equal_next = meq_g;
                        field_count_next = fc_inc;
                        if (fields_done)
                            phase_next = meq_g ? lse_pkg::PH_EXTLEN : lse_pkg::PH_IDLE;
                    end
                    else if (ph == lse_pkg::PH_EXTCHR)
                    begin
                        field_count_next = fc_inc;
                        if (fields_done)
                            phase_next = lse_pkg::PH_SIZE;
                    end
                    else
                    begin
                        payload_left_next = pl_dec;
                        if (pl_dec == '0)
                            phase_next = lse_pkg::PH_IDLE;
                    end
                end
            end
            lse_pkg::PH_EXTLEN, lse_pkg::PH_SIZE:
            begin
                bit_count_next  = bc_inc[4:0];
                shift_bits_next = sh_g;
                if (word_done)
                begin
                    bit_count_next  = '0;
                    shift_bits_next = '0;
                    if (ph == lse_pkg::PH_EXTLEN)
                    begin
                        if (w >= {24'd0, cfg.ext_limit})
                            phase_next = lse_pkg::PH_IDLE;
                        else
                        begin
                            field_count_next  = '0;
                            field_target_next = w[7:0];
                            phase_next = (w == '0) ? lse_pkg::PH_SIZE : lse_pkg::PH_EXTCHR;
                        end
                    end
                    else if (w == '0 || w[31])
                        phase_next = lse_pkg::PH_IDLE;
                    else
                    begin
                        payload_left_next = w[30:0];
                        phase_next        = lse_pkg::PH_DATA;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result for this item
    always_comb
    begin
        res.valid           = 1'b0;
        res.data.kind       = lse_pkg::KIND_MAGIC_OK;
        res.data.byte_value = '0;
        res.data.size_value = '0;
        res.data.last       = 1'b0;

        case (ph)
            lse_pkg::PH_MAGIC:
            begin
                if (byte_done && fields_done)
                begin
                    res.valid = 1'b1;
                    if (!meq_g)
                    begin
                        res.data.kind = lse_pkg::KIND_MAGIC_BAD;
                        res.data.last = 1'b1;
                    end
                end
            end
            lse_pkg::PH_EXTCHR:
            begin
                if (byte_done)
                begin
                    res.valid           = 1'b1;
                    res.data.kind       = lse_pkg::KIND_EXT_CHAR;
                    res.data.byte_value = b;
                end
            end
            lse_pkg::PH_DATA:
            begin
                if (byte_done)
                begin
                    res.valid           = 1'b1;
                    res.data.kind       = lse_pkg::KIND_PAYLOAD_BYTE;
                    res.data.byte_value = b;
                    res.data.last       = (pl_dec == '0);
                end
            end
            lse_pkg::PH_EXTLEN:
            begin
                if (word_done)
                begin
                    res.valid           = 1'b1;
                    res.data.size_value = w;
                    if (w >= {24'd0, cfg.ext_limit})
                    begin
                        res.data.kind = lse_pkg::KIND_EXT_TOO_LONG;
                        res.data.last = 1'b1;
                    end
                    else
                        res.data.kind = lse_pkg::KIND_EXT_LENGTH;
                end
            end
            lse_pkg::PH_SIZE:
            begin
                if (word_done)
                begin
                    res.valid           = 1'b1;
                    res.data.kind       = lse_pkg::KIND_PAYLOAD_SIZE;
                    res.data.size_value = w;
                    res.data.last       = (w == '0) || w[31];
                end
            end
            default: ;
        endcase
    end

    // State registers advance once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lse_pkg::PH_HEADER;
            header_count_reg <= '0;
            bit_count_reg    <= '0;
            shift_bits_reg   <= '0;
            field_count_reg  <= '0;
            field_target_reg <= '0;
            magic_equal_reg  <= 1'b1;
            payload_left_reg <= '0;
        end
        else if (proc)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_count_reg    <= bit_count_next;
            shift_bits_reg   <= shift_bits_next;
            field_count_reg  <= field_count_next;
            field_target_reg <= field_target_next;
            magic_equal_reg  <= magic_equal_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lse_out_stage.sv
`default_nettype none

module lse_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               proc,
    input  wire lse_pkg::lse_res_t  res,
    input  wire logic               out_stall,
    output logic                    advance,
    output logic                    out_valid,
    output lse_pkg::lse_out_t       out_data
);

    logic              out_valid_reg, out_valid_next;
    lse_pkg::lse_out_t out_data_reg;

    // Register is free when empty or being drained this cycle
    assign advance        = !out_valid_reg || !out_stall;
    assign out_valid_next = advance ? (proc && res.valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && proc && res.valid)
            out_data_reg <= res.data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/lsb_stego_extractor_core.sv
// LSB stego extractor: recovers a hidden stream from stego BMP file bytes.
// Input channel (in_valid/in_stall/in_data): one file byte per transfer,
// with first_byte set on the first byte of each file. The first 54 bytes
// are skipped; after that bit 0 of each byte is gathered, LSB first.
// Output channel (out_valid/out_stall/out_data): zero or one result per
// input byte (magic check, extension length and chars, payload size and
// bytes, or an error), with last set on the final result of a stream.
// A result reaches out_valid through the input register, then the result
// register. Throughput: one byte per cycle while out_stall does not hold a
// pending result, set by the single decode step between the input register
// and the result register. Stall: while out_stall holds a pending result,
// at most one more byte is taken into the input register and in_stall then
// rises until the result drains. Reset: clears the stream state to header
// skipping and empties both registers; configuration returns to magic
// 0x2A23, length 2, limit 8. The user must write configuration over the
// APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module lsb_stego_extractor_core
#(
    parameter int MAGIC_MAX_BYTES = lse_pkg::LSE_MAGIC_MAX_BYTES
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire lse_pkg::lse_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lse_pkg::lse_out_t                    out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lse_pkg::LSE_ADDR_W-1:0]  paddr,
    input  wire logic [lse_pkg::LSE_DATA_W-1:0]  pwdata,
    output logic      [lse_pkg::LSE_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    lse_pkg::lse_cfg_t cfg;
    lse_pkg::lse_res_t res;
    lse_pkg::lse_in_t  in_data_reg;
    logic              in_valid_reg, in_valid_next;
    logic              advance, proc;

    // Input register: holds while stalled, else loads whatever is offered
    assign in_stall      = in_valid_reg && !advance;
    assign proc          = in_valid_reg && advance;
    assign in_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_data;
    end

    lse_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lse_decoder
    #(
        .MAGIC_MAX_BYTES (MAGIC_MAX_BYTES)
    )
    u_dec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .proc  (proc),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (res)
    );

    lse_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .res       (res),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
